>>> rtl/core/totp_pkg.sv
// Shared types, constants and helpers for the one-time code generator.
`timescale 1ns / 1ps

package totp_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_st_t;

  typedef logic [15:0][31:0] wwin_t;

  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_KEY_UPPER   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_MIDDLE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOWER   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIME_ORIGIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP        = 3'd4;

  localparam logic [15:0] STEP_RESET = 16'd30;

  localparam sha_st_t SHA_IV = '{
    a: 32'h67452301, b: 32'hEFCDAB89, c: 32'h98BADCFE, d: 32'h10325476, e: 32'hC3D2E1F0
  };

  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;
  localparam logic [7:0] MSG_END = 8'h80;

  // message lengths in bits: 64 pad bytes plus counter, 64 pad bytes plus inner digest
  localparam logic [63:0] INNER_LEN_BITS = 64'd576;
  localparam logic [63:0] OUTER_LEN_BITS = 64'd672;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic wwin_t to_words(input logic [511:0] blk);
    wwin_t w;
    for (int i = 0; i < 16; i++) begin
      w[i] = blk[511 - 32 * i -: 32];
    end
    to_words = w;
  endfunction

endpackage

>>> rtl/core/totp_div_cell.sv
// One restoring-division cell: retires one quotient bit per stage.
`timescale 1ns / 1ps

module totp_div_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] dq_i,
  input  logic [15:0] rem_i,
  input  logic [15:0] div_i,
  output logic        valid_o,
  output logic [63:0] dq_o,
  output logic [15:0] rem_o,
  output logic [15:0] div_o
);

  logic        valid_q;
  logic [63:0] dq_q, dq_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] div_q;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial = {rem_i, dq_i[63]};
    diff  = trial - {1'b0, div_i};
    if (trial >= {1'b0, div_i}) begin
      rem_d = diff[15:0];
      dq_d  = {dq_i[62:0], 1'b1};
    end else begin
      rem_d = trial[15:0];
      dq_d  = {dq_i[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
      div_q <= div_i;
    end
  end

  assign valid_o = valid_q;
  assign dq_o    = dq_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;

endmodule

>>> rtl/core/totp_sha_round.sv
// One SHA-1 round cell with its rolling message schedule window.
`timescale 1ns / 1ps

module totp_sha_round #(
  parameter int ROUND  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  totp_pkg::sha_st_t     st_i,
  input  totp_pkg::sha_st_t     h_i,
  input  totp_pkg::wwin_t       w_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output totp_pkg::sha_st_t     st_o,
  output totp_pkg::sha_st_t     h_o,
  output totp_pkg::wwin_t       w_o,
  output logic [SIDE_W-1:0]     side_o
);
  import totp_pkg::*;

  logic              valid_q;
  sha_st_t           st_q, st_d;
  sha_st_t           h_q;
  wwin_t             w_q, w_d;
  logic [SIDE_W-1:0] side_q;
  logic [31:0]       f;
  logic [31:0]       k;
  logic [31:0]       t;

  always_comb begin
    if (ROUND < 20) begin
      f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      k = 32'h5A827999;
    end else if (ROUND < 40) begin
      f = st_i.b ^ st_i.c ^ st_i.d;
      k = 32'h6ED9EBA1;
    end else if (ROUND < 60) begin
      f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
      k = 32'h8F1BBCDC;
    end else begin
      f = st_i.b ^ st_i.c ^ st_i.d;
      k = 32'hCA62C1D6;
    end
    t = rotl(st_i.a, 5) + f + st_i.e + k + w_i[0];
    st_d.a = t;
    st_d.b = st_i.a;
    st_d.c = rotl(st_i.b, 30);
    st_d.d = st_i.c;
    st_d.e = st_i.d;
    for (int i = 0; i < 15; i++) begin
      w_d[i] = w_i[i + 1];
    end
    w_d[15] = rotl(w_i[13] ^ w_i[8] ^ w_i[2] ^ w_i[0], 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q   <= st_d;
      h_q    <= h_i;
      w_q    <= w_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign h_o     = h_q;
  assign w_o     = w_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/totp_sha_blk.sv
// One SHA-1 block compression: 80 round cells and the chaining add.
`timescale 1ns / 1ps

module totp_sha_blk #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  totp_pkg::sha_st_t     h_i,
  input  totp_pkg::wwin_t       blk_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output totp_pkg::sha_st_t     dig_o,
  output logic [SIDE_W-1:0]     side_o
);
  import totp_pkg::*;

  logic              v_w    [81];
  sha_st_t           st_w   [81];
  sha_st_t           h_w    [81];
  wwin_t             w_w    [81];
  logic [SIDE_W-1:0] side_w [81];

  logic              valid_q;
  sha_st_t           dig_q, dig_d;
  logic [SIDE_W-1:0] side_q;

  assign v_w[0]    = valid_i;
  assign st_w[0]   = h_i;
  assign h_w[0]    = h_i;
  assign w_w[0]    = blk_i;
  assign side_w[0] = side_i;

  for (genvar r = 0; r < 80; r++) begin : g_round
    totp_sha_round #(
      .ROUND  (r),
      .SIDE_W (SIDE_W)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (v_w[r]),
      .st_i    (st_w[r]),
      .h_i     (h_w[r]),
      .w_i     (w_w[r]),
      .side_i  (side_w[r]),
      .valid_o (v_w[r + 1]),
      .st_o    (st_w[r + 1]),
      .h_o     (h_w[r + 1]),
      .w_o     (w_w[r + 1]),
      .side_o  (side_w[r + 1])
    );
  end

  always_comb begin
    dig_d.a = h_w[80].a + st_w[80].a;
    dig_d.b = h_w[80].b + st_w[80].b;
    dig_d.c = h_w[80].c + st_w[80].c;
    dig_d.d = h_w[80].d + st_w[80].d;
    dig_d.e = h_w[80].e + st_w[80].e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= v_w[80];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dig_q  <= dig_d;
      side_q <= side_w[80];
    end
  end

  assign valid_o = valid_q;
  assign dig_o   = dig_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/totp_code_generator.sv
// Top level of the HMAC-SHA1 one-time code generator.
// Usage:
//   Input channel: in_valid_i / in_stall_o carry func_i and value_i. With func_i
//   low, value_i is a Unix time and the counter is (value - origin) / step, or
//   zero before the origin; with func_i high, value_i is the counter itself.
//   Output channel: out_valid_o / out_stall_i carry code_o, one per transaction.
//   Configuration: cfg_valid_i / cfg_ready_o write key, origin and step by
//   index; write only while no transaction is in flight.
//   Throughput: one transaction per cycle unless the output is stalled. From
//   input acceptance to out_valid_o a code passes the entry register, the
//   64-cell divider, four SHA-1 block stages of 81 registers each (80 round
//   cells plus the chaining add), and three truncation/reduction stages.
//   A stalled output freezes the whole cell chain; in_stall_o rises in the
//   same cycle, and the held code stays on code_o.
//   Reset empties the chain and loads key zero, origin zero, step 30.
`timescale 1ns / 1ps

module totp_code_generator #(
  parameter int CODE_DIGITS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [63:0]                    value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [19:0]                    code_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [totp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);
  import totp_pkg::*;

  localparam logic [63:0] MOD   = 64'(10 ** CODE_DIGITS);
  localparam int          MODW  = $clog2(10 ** CODE_DIGITS);
  localparam int          RSH   = 31 + MODW;
  localparam logic [63:0] RECIP = ((64'd1 << RSH) + MOD - 64'd1) / MOD;

  logic [63:0] key_upper_q, key_middle_q;
  logic [31:0] key_lower_q;
  logic [62:0] time_origin_q;
  logic [15:0] step_q;

  logic en;
  logic [511:0] key_blk;

  assign cfg_ready_o = 1'b1;
  assign key_blk = {key_upper_q, key_middle_q, key_lower_q, 352'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q   <= '0;
      key_middle_q  <= '0;
      key_lower_q   <= '0;
      time_origin_q <= '0;
      step_q        <= STEP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KEY_UPPER:   key_upper_q   <= cfg_data_i;
        CFG_KEY_MIDDLE:  key_middle_q  <= cfg_data_i;
        CFG_KEY_LOWER:   key_lower_q   <= cfg_data_i[31:0];
        CFG_TIME_ORIGIN: time_origin_q <= cfg_data_i[62:0];
        CFG_STEP:        step_q        <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Global advance: the chain moves unless the output register is held.
  logic out_v_q;
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // Entry stage: dividend and divisor selection
  logic        s0_v_q;
  logic [63:0] s0_dq_q, s0_dq_d;
  logic [15:0] s0_div_q, s0_div_d;

  always_comb begin
    if (func_i) begin
      s0_dq_d  = value_i;
      s0_div_d = 16'd1;
    end else begin
      s0_dq_d  = (value_i < {1'b0, time_origin_q}) ? 64'd0 : value_i - {1'b0, time_origin_q};
      s0_div_d = (step_q == 16'd0) ? 16'd1 : step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_dq_q  <= s0_dq_d;
      s0_div_q <= s0_div_d;
    end
  end

  // Divider chain
  logic        dv_w  [65];
  logic [63:0] ddq_w [65];
  logic [15:0] drem_w[65];
  logic [15:0] ddiv_w[65];

  assign dv_w[0]   = s0_v_q;
  assign ddq_w[0]  = s0_dq_q;
  assign drem_w[0] = 16'd0;
  assign ddiv_w[0] = s0_div_q;

  for (genvar i = 0; i < 64; i++) begin : g_div
    totp_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_w[i]),
      .dq_i    (ddq_w[i]),
      .rem_i   (drem_w[i]),
      .div_i   (ddiv_w[i]),
      .valid_o (dv_w[i + 1]),
      .dq_o    (ddq_w[i + 1]),
      .rem_o   (drem_w[i + 1]),
      .div_o   (ddiv_w[i + 1])
    );
  end

  // Inner hash, first block
  logic        b1_v;
  sha_st_t     b1_dig;
  logic [63:0] b1_ctr;

  totp_sha_blk #(.SIDE_W(64)) u_inner1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_w[64]),
    .h_i     (SHA_IV),
    .blk_i   (to_words(key_blk ^ {64{IPAD}})),
    .side_i  (ddq_w[64]),
    .valid_o (b1_v),
    .dig_o   (b1_dig),
    .side_o  (b1_ctr)
  );

  // Inner hash, counter block
  logic    b2_v;
  sha_st_t b2_dig;

  totp_sha_blk #(.SIDE_W(1)) u_inner2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b1_v),
    .h_i     (b1_dig),
    .blk_i   (to_words({b1_ctr, MSG_END, 376'd0, INNER_LEN_BITS})),
    .side_i  (1'b0),
    .valid_o (b2_v),
    .dig_o   (b2_dig),
    .side_o  ()
  );

  // Outer hash, key block
  logic         b3_v;
  sha_st_t      b3_dig;
  logic [159:0] b3_inner;

  totp_sha_blk #(.SIDE_W(160)) u_outer1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b2_v),
    .h_i     (SHA_IV),
    .blk_i   (to_words(key_blk ^ {64{OPAD}})),
    .side_i  (b2_dig),
    .valid_o (b3_v),
    .dig_o   (b3_dig),
    .side_o  (b3_inner)
  );

  // Outer hash, inner digest block
  logic    b4_v;
  sha_st_t b4_dig;

  totp_sha_blk #(.SIDE_W(1)) u_outer2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b3_v),
    .h_i     (b3_dig),
    .blk_i   (to_words({b3_inner, MSG_END, 280'd0, OUTER_LEN_BITS})),
    .side_i  (1'b0),
    .valid_o (b4_v),
    .dig_o   (b4_dig),
    .side_o  ()
  );

  // Dynamic truncation and reduction by reciprocal multiply
  logic [159:0] mac_shift;
  logic         t1_v_q, t2_v_q;
  logic [30:0]  t1_p_q, t1_p_d;
  logic [30:0]  t2_p_q;
  logic [30:0]  t2_q_q, t2_q_d;
  logic [63:0]  prod;
  logic [63:0]  qm;
  logic [63:0]  rem;
  logic [19:0]  code_q, code_d;

  always_comb begin
    mac_shift = b4_dig << {b4_dig.e[3:0], 3'b000};
    t1_p_d    = mac_shift[158:128];
    prod      = 64'(t1_p_q) * RECIP;
    t2_q_d    = 31'(prod >> RSH);
    qm        = 64'(t2_q_q) * MOD;
    rem       = 64'(t2_p_q) - qm;
    code_d    = rem[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      t1_v_q  <= b4_v;
      t2_v_q  <= t1_v_q;
      out_v_q <= t2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_p_q <= t1_p_d;
      t2_p_q <= t1_p_q;
      t2_q_q <= t2_q_d;
      code_q <= code_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign code_o      = code_q;

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({44'd0, code_o} < MOD))
    else $error("code out of range");

  a_entry_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (s0_v_q == $past(in_valid_i)))
    else $error("entry stage missed a transaction");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s0_v_q) && $stable(t2_v_q)))
    else $error("chain moved while output held");

endmodule

>>> dv/tb.sv
// Testbench for the HMAC-SHA1 one-time code generator: random and directed codes checked in order.
`timescale 1ns / 1ps

class code_board;
  bit [19:0] pending_codes[$];
  int        errors;

  function void note_code(bit [19:0] c);
    pending_codes.push_back(c);
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_code(bit [19:0] got);
    bit [19:0] want;
    if (pending_codes.size() == 0) begin
      report($sformatf("code %0d with none pending", got));
    end else begin
      want = pending_codes.pop_front();
      if (got !== want) begin
        report($sformatf("code got %0d want %0d", got, want));
      end
    end
  endtask
endclass

module tb;
  import totp_pkg::*;

  localparam int Latency = 392;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [19:0] code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  totp_code_generator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  code_board board = new();

  bit [63:0]  key_hi, key_mid;
  bit [31:0]  key_lo;
  bit [62:0]  origin;
  bit [15:0]  step_len;
  bit         idle_on = 1'b1;

  function automatic bit [31:0] rl(bit [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha_compress(inout bit [31:0] h[5], input bit [511:0] blk);
    bit [31:0] w[80];
    bit [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
      else if (i < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
      else if (i < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
      else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
      t = rl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rl(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endfunction

  // message: 64-byte padded key block, then tail bytes; total tail <= 55 bytes
  function automatic bit [159:0] sha_pad_key(bit [511:0] kblk, bit [511:0] tail_blk);
    bit [31:0] h[5];
    h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    sha_compress(h, kblk);
    sha_compress(h, tail_blk);
    return {h[0], h[1], h[2], h[3], h[4]};
  endfunction

  function automatic bit [19:0] predict_code(bit fn, bit [63:0] v);
    bit [63:0]  counter, stp;
    bit [511:0] key, ib, ob, tail;
    bit [159:0] inner, mac;
    bit [31:0]  p;
    int         off;
    longint unsigned modulus;
    if (fn) counter = v;
    else begin
      stp = (step_len == 0) ? 64'd1 : 64'(step_len);
      counter = (v < 64'(origin)) ? 64'd0 : (v - 64'(origin)) / stp;
    end
    key = {key_hi, key_mid, key_lo, 352'd0};
    ib = key ^ {64{8'h36}};
    ob = key ^ {64{8'h5c}};
    tail = {counter, 8'h80, 376'd0, 64'd576};
    inner = sha_pad_key(ib, tail);
    tail = {inner, 8'h80, 280'd0, 64'd672};
    mac = sha_pad_key(ob, tail);
    off = mac[3:0];
    p = mac[159 - 8 * off -: 32] & 32'h7fffffff;
    modulus = 1;
    for (int i = 0; i < 6; i++) modulus *= 10;
    return 20'(longint'(p) % modulus);
  endfunction

  task automatic write_reg(bit [CfgIdxW-1:0] idx, bit [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_KEY_UPPER:   key_hi = data;
      CFG_KEY_MIDDLE:  key_mid = data;
      CFG_KEY_LOWER:   key_lo = data[31:0];
      CFG_TIME_ORIGIN: origin = data[62:0];
      CFG_STEP:        step_len = data[15:0];
      default: ;
    endcase
  endtask

  task automatic send_item(bit fn, bit [63:0] v);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    value_i <= v;
    board.note_code(predict_code(fn, v));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_code(code_o);
    out_stall_i <= idle_on && ($urandom_range(99) < 20);
  end

  task automatic rand_item();
    bit [63:0] v;
    case ($urandom_range(3))
      0: v = rand64();
      1: v = 64'(origin) + $urandom_range(200000);
      2: v = 64'(origin) - $urandom_range(3);
      default: v = $urandom_range(3) == 0 ? 64'hffff_ffff_ffff_ffff : 64'($urandom());
    endcase
    send_item($urandom_range(1), v);
  endtask

  initial begin
    key_hi = 0; key_mid = 0; key_lo = 0; origin = 0; step_len = STEP_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_item(1'b1, 64'd0);
    send_item(1'b0, 64'd59);
    drain();
    write_reg(CFG_KEY_UPPER, 64'h3132333435363738);
    write_reg(CFG_KEY_MIDDLE, 64'h3930313233343536);
    write_reg(CFG_KEY_LOWER, 64'h37383930);
    for (int i = 0; i < 10; i++) send_item(1'b1, 64'(i));
    send_item(1'b0, 64'd59);
    send_item(1'b0, 64'hffff_ffff_ffff_ffff);
    send_item(1'b1, 64'hffff_ffff_ffff_ffff);
    send_item(1'b1, 64'h8000_0000_0000_0000);
    drain();
    write_reg(CFG_TIME_ORIGIN, 64'h7fff_ffff_ffff_fff0);
    write_reg(CFG_STEP, 64'd0);
    send_item(1'b0, 64'd5);
    send_item(1'b0, 64'h7fff_ffff_ffff_fff0);
    send_item(1'b0, 64'hffff_ffff_ffff_ffff);
    drain();
    write_reg(CFG_STEP, 64'd65535);
    send_item(1'b0, 64'hffff_ffff_ffff_ffff);
    send_item(1'b0, 64'h7fff_ffff_ffff_ffef);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_KEY_UPPER, ph == 0 ? 64'hffff_ffff_ffff_ffff : rand64());
      write_reg(CFG_KEY_MIDDLE, ph == 0 ? 64'hffff_ffff_ffff_ffff : rand64());
      write_reg(CFG_KEY_LOWER, ph == 0 ? 64'hffff_ffff : 64'($urandom()));
      write_reg(CFG_TIME_ORIGIN, ph == 1 ? 64'd0 : {1'b0, rand64()} >> (ph * 10));
      write_reg(CFG_STEP, ph == 2 ? 64'd1 : ph == 3 ? 64'd65535 : 64'($urandom_range(65535)));
      idle_on = (ph != 4);
      for (int n = 0; n < 270; n++) begin
        if (n == 135 && ph == 1) drain();
        rand_item();
      end
      idle_on = 1'b1;
    end
    drain();
    if (board.errors == 0) $display("totp_code_generator verification clean");
    else $display("totp_code_generator verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("totp_code_generator verification failed");
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/totp_pkg.sv
rtl/core/totp_div_cell.sv
rtl/core/totp_sha_round.sv
rtl/core/totp_sha_blk.sv
rtl/core/totp_code_generator.sv
dv/tb.sv
